>>> hdl/cartridge_bank_controller_mode_select_defines.svh
// assertion macros used by the checker file of the bank controller
`ifndef CARTRIDGE_BANK_CONTROLLER_MODE_SELECT_DEFINES_SVH
`define CARTRIDGE_BANK_CONTROLLER_MODE_SELECT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CBCMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CBCMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cbcms_pkg.sv
// shared types, constants and codes of the cartridge bank controller
package cbcms_pkg;

  // address widths of the physical memories
  localparam int ROM_ADDR_BITS = 21;
  localparam int RAM_ADDR_BITS = 15;

  localparam int MAP_W = 21;
  localparam logic [MAP_W-1:0] ROM_MASK = MAP_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);
  localparam logic [MAP_W-1:0] RAM_MASK = MAP_W'((64'd1 << RAM_ADDR_BITS) - 64'd1);

  // remainder unit: dividend and divisor widths, step counter width
  localparam int DIV_W     = 15;
  localparam int DVSR_W    = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // low nibble that enables cartridge ram
  localparam logic [3:0] RAM_EN_KEY = 4'hA;

  typedef enum logic [1:0] {
    CFG_ROM_BANK_COUNT = 2'd0,
    CFG_RAM_BYTES      = 2'd1
  } cbcms_cfg_idx_t;

  typedef enum logic [2:0] {
    TGT_UNMAPPED = 3'd0,
    TGT_ROM      = 3'd1,
    TGT_RAM_RD   = 3'd2,
    TGT_RAM_WR   = 3'd3,
    TGT_OPEN_BUS = 3'd4,
    TGT_REG_WR   = 3'd5
  } cbcms_target_t;

  // 8 KiB regions selected by bus_address[15:13]
  typedef enum logic [2:0] {
    RGN_RAM_EN   = 3'd0,
    RGN_BANK_LO  = 3'd1,
    RGN_BANK_HI  = 3'd2,
    RGN_MODE     = 3'd3,
    RGN_VIDEO    = 3'd4,
    RGN_CART_RAM = 3'd5,
    RGN_WORK_RAM = 3'd6,
    RGN_HIGH     = 3'd7
  } cbcms_region_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIVIDE,
    ST_COMMIT
  } cbcms_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic commit;
  } cbcms_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } cbcms_status_t;

endpackage

>>> hdl/cartridge_bank_controller_mode_select.sv
// top level of the single-mode-bit cartridge bank controller
// Translates one CPU bus access per item into a ROM or cartridge-RAM byte
// address, an open-bus read, an unmapped read or an absorbed register write,
// and keeps the ram enable, banking mode and the 5+2 bit bank registers.
// An item is taken while the controller is idle and its result lands in an
// output register, so a waiting result does not block the next item. Every
// item passes through capture, decode and commit on its way to the result
// register. Writes to either bank register with a nonzero bank count,
// and mapped RAM accesses in banking mode 1, also go through the shared
// remainder unit, which retires one dividend bit per cycle over 15 bits
// before commit. Config writes are taken every cycle (cfg_ready is
// always high); index 0 is the ROM bank count, index 1 the RAM size in bytes,
// other indexes are ignored. A config write does not re-reduce the current
// bank. There is no clearing pass after reset.
module cartridge_bank_controller_mode_select (
  input  logic                        clk,
  input  logic                        rst_n,
  // access items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [15:0]                 in_bus_address,
  input  logic [7:0]                  in_write_data,
  // result items
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_target,
  output logic [cbcms_pkg::MAP_W-1:0] out_mapped_address,
  output logic [7:0]                  out_ram_write_data,
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [15:0]                 cfg_data
);

  cbcms_pkg::cbcms_cmd_t    cmd;
  cbcms_pkg::cbcms_status_t status;

  // config registers are plain flops, never busy
  assign cfg_ready = 1'b1;

  // sequencing: idle, decode, optional remainder wait, commit
  cbcms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // registers, decode, remainder unit and result register
  cbcms_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_req_type        (in_req_type),
    .in_bus_address     (in_bus_address),
    .in_write_data      (in_write_data),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_target         (out_target),
    .out_mapped_address (out_mapped_address),
    .out_ram_write_data (out_ram_write_data)
  );

endmodule

>>> hdl/cbcms_rem.sv
// iterative restoring remainder unit, one dividend bit per cycle
module cbcms_rem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cbcms_pkg::DIV_W-1:0]   dividend,
  input  logic [cbcms_pkg::DVSR_W-1:0]  divisor,
  output logic                          done,
  output logic [cbcms_pkg::DVSR_W-1:0]  rem
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [cbcms_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [cbcms_pkg::DIV_W-1:0]      num_r, num_nxt;
  logic [cbcms_pkg::DVSR_W-1:0]     dvsr_r, dvsr_nxt;
  logic [cbcms_pkg::DVSR_W-1:0]     rem_r, rem_nxt;
  logic [cbcms_pkg::DVSR_W:0]       trial;
  logic [cbcms_pkg::DVSR_W+1:0]     diff;

  assign trial = {rem_r, num_r[cbcms_pkg::DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    dvsr_nxt = dvsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = dividend;
      dvsr_nxt = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // keep the partial remainder below the divisor
      rem_nxt = diff[cbcms_pkg::DVSR_W+1] ? trial[cbcms_pkg::DVSR_W-1:0]
                                          : diff[cbcms_pkg::DVSR_W-1:0];
      num_nxt = {num_r[cbcms_pkg::DIV_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == cbcms_pkg::DIV_CNT_W'(cbcms_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    dvsr_r <= dvsr_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> hdl/cbcms_ctrl.sv
// sequencing state machine of the bank controller
module cbcms_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cbcms_pkg::cbcms_status_t status,
  output cbcms_pkg::cbcms_cmd_t    cmd
);

  cbcms_pkg::cbcms_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbcms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      cbcms_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = cbcms_pkg::ST_DECODE;
        end
      end
      cbcms_pkg::ST_DECODE: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = cbcms_pkg::ST_DIVIDE;
        end else begin
          state_nxt = cbcms_pkg::ST_COMMIT;
        end
      end
      cbcms_pkg::ST_DIVIDE: begin
        if (status.div_done) begin
          state_nxt = cbcms_pkg::ST_COMMIT;
        end
      end
      cbcms_pkg::ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = cbcms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cbcms_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/cbcms_dp.sv
// datapath: config and mapper registers, address decode, result register
module cbcms_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cbcms_pkg::cbcms_cmd_t             cmd,
  output cbcms_pkg::cbcms_status_t          status,
  input  logic                              in_req_type,
  input  logic [15:0]                       in_bus_address,
  input  logic [7:0]                        in_write_data,
  input  logic                              cfg_valid,
  input  logic [1:0]                        cfg_index,
  input  logic [15:0]                       cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_target,
  output logic [cbcms_pkg::MAP_W-1:0]       out_mapped_address,
  output logic [7:0]                        out_ram_write_data
);

  // captured item
  logic        req_write_r;
  logic [15:0] req_addr_r;
  logic [7:0]  req_data_r;

  // configuration
  logic [7:0]  rom_banks_r, rom_banks_nxt;
  logic [15:0] ram_bytes_r, ram_bytes_nxt;

  // mapper state
  logic        ram_en_r, ram_en_nxt;
  logic        mode_r, mode_nxt;
  logic [4:0]  bank_lo_r, bank_lo_nxt;
  logic [1:0]  bank_hi_r, bank_hi_nxt;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  cbcms_pkg::cbcms_target_t      out_tgt_r;
  logic [cbcms_pkg::MAP_W-1:0]   out_map_r;
  logic [7:0]                    out_wd_r;

  cbcms_pkg::cbcms_region_t      rgn;
  logic [12:0]                   off;
  logic                          ram_hit;
  logic                          ram_ok;
  logic                          bank_wr;
  logic                          reduce;
  logic [6:0]                    full_new;
  logic [cbcms_pkg::DIV_W-1:0]   ram_sum;
  logic [cbcms_pkg::DIV_W-1:0]   dividend;
  logic [cbcms_pkg::DVSR_W-1:0]  divisor;
  logic                          div_done;
  logic [cbcms_pkg::DVSR_W-1:0]  rem;
  logic [14:0]                   ram_phys;
  logic [cbcms_pkg::MAP_W-1:0]   ram_map;
  logic [4:0]                    low_eff;
  logic [6:0]                    sel_bank;
  logic [cbcms_pkg::MAP_W-1:0]   rom_map;
  cbcms_pkg::cbcms_target_t      res_tgt;
  logic [cbcms_pkg::MAP_W-1:0]   res_map;
  logic [7:0]                    res_wd;

  // decode of the captured item
  assign rgn      = cbcms_pkg::cbcms_region_t'(req_addr_r[15:13]);
  assign off      = req_addr_r[12:0];
  assign ram_hit  = (rgn == cbcms_pkg::RGN_CART_RAM);
  assign ram_ok   = ram_en_r && ({3'b000, off} < ram_bytes_r);
  assign bank_wr  = req_write_r &&
                    ((rgn == cbcms_pkg::RGN_BANK_LO) || (rgn == cbcms_pkg::RGN_BANK_HI));
  assign reduce   = (rom_banks_r != 8'd0);
  assign full_new = (rgn == cbcms_pkg::RGN_BANK_LO) ? {bank_hi_r, req_data_r[4:0]}
                                                    : {req_data_r[1:0], bank_lo_r};
  assign ram_sum  = {2'b00, off} + {bank_hi_r, 13'd0};

  assign dividend = bank_wr ? {8'd0, full_new} : ram_sum;
  assign divisor  = bank_wr ? {8'd0, rom_banks_r} : ram_bytes_r;

  assign status.need_div = (bank_wr && reduce) || (ram_hit && ram_ok && mode_r);
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || out_ready;

  cbcms_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .rem      (rem)
  );

  // physical addresses
  assign ram_phys = mode_r ? rem[14:0] : {2'b00, off};
  assign ram_map  = {6'd0, ram_phys} & cbcms_pkg::RAM_MASK;
  assign low_eff  = (bank_lo_r == 5'd0) ? 5'd1 : bank_lo_r;
  assign sel_bank = {(mode_r ? 2'b00 : bank_hi_r), low_eff};
  assign rom_map  = req_addr_r[14] ? ({sel_bank, req_addr_r[13:0]} & cbcms_pkg::ROM_MASK)
                                   : {5'd0, req_addr_r};

  always_comb begin
    res_tgt = cbcms_pkg::TGT_UNMAPPED;
    res_map = '0;
    res_wd  = '0;
    if (!req_write_r) begin
      if (!req_addr_r[15]) begin
        res_tgt = cbcms_pkg::TGT_ROM;
        res_map = rom_map;
      end else if (ram_hit) begin
        if (ram_ok) begin
          res_tgt = cbcms_pkg::TGT_RAM_RD;
          res_map = ram_map;
        end else begin
          res_tgt = cbcms_pkg::TGT_OPEN_BUS;
        end
      end
    end else begin
      res_tgt = cbcms_pkg::TGT_REG_WR;
      if (ram_hit && ram_ok) begin
        res_tgt = cbcms_pkg::TGT_RAM_WR;
        res_map = ram_map;
        res_wd  = req_data_r;
      end
    end
  end

  // mapper and config register updates
  always_comb begin
    rom_banks_nxt = rom_banks_r;
    ram_bytes_nxt = ram_bytes_r;
    ram_en_nxt    = ram_en_r;
    mode_nxt      = mode_r;
    bank_lo_nxt   = bank_lo_r;
    bank_hi_nxt   = bank_hi_r;
    if (cfg_valid) begin
      case (cfg_index)
        cbcms_pkg::CFG_ROM_BANK_COUNT: rom_banks_nxt = cfg_data[7:0];
        cbcms_pkg::CFG_RAM_BYTES:      ram_bytes_nxt = cfg_data;
        default: ;
      endcase
    end
    if (cmd.commit && req_write_r) begin
      case (rgn)
        cbcms_pkg::RGN_RAM_EN: begin
          ram_en_nxt = (req_data_r[3:0] == cbcms_pkg::RAM_EN_KEY);
        end
        cbcms_pkg::RGN_BANK_LO, cbcms_pkg::RGN_BANK_HI: begin
          if (reduce) begin
            {bank_hi_nxt, bank_lo_nxt} = rem[6:0];
          end else begin
            {bank_hi_nxt, bank_lo_nxt} = full_new;
          end
        end
        cbcms_pkg::RGN_MODE: begin
          mode_nxt = req_data_r[0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_banks_r <= 8'd2;
      ram_bytes_r <= 16'd0;
      ram_en_r    <= 1'b0;
      mode_r      <= 1'b0;
      bank_lo_r   <= 5'd1;
      bank_hi_r   <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      rom_banks_r <= rom_banks_nxt;
      ram_bytes_r <= ram_bytes_nxt;
      ram_en_r    <= ram_en_nxt;
      mode_r      <= mode_nxt;
      bank_lo_r   <= bank_lo_nxt;
      bank_hi_r   <= bank_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_write_r <= in_req_type;
      req_addr_r  <= in_bus_address;
      req_data_r  <= in_write_data;
    end
    if (cmd.commit) begin
      out_tgt_r <= res_tgt;
      out_map_r <= res_map;
      out_wd_r  <= res_wd;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_target         = out_tgt_r;
  assign out_mapped_address = out_map_r;
  assign out_ram_write_data = out_wd_r;

endmodule

>>> hdl/cbcms_checker.sv
// port-level checks of the bank controller and their bind
`include "cartridge_bank_controller_mode_select_defines.svh"

module cbcms_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [2:0]                  out_target,
  input logic [cbcms_pkg::MAP_W-1:0] out_mapped_address,
  input logic [7:0]                  out_ram_write_data
);

  // a stalled result keeps its fields
  `CBCMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_target) && $stable(out_mapped_address) && $stable(out_ram_write_data), "stalled result changed")

  // one item at a time: busy right after taking an item
  `CBCMS_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "item taken while busy")

  // only rom and ram targets carry an address
  `CBCMS_ASSERT_NOW(a_no_addr, out_valid && (out_target == cbcms_pkg::TGT_UNMAPPED || out_target == cbcms_pkg::TGT_OPEN_BUS || out_target == cbcms_pkg::TGT_REG_WR), out_mapped_address == '0, "address on non-memory target")

  // write data only for ram writes
  `CBCMS_ASSERT_NOW(a_wdata_ram_wr, out_valid && out_target != cbcms_pkg::TGT_RAM_WR, out_ram_write_data == 8'd0, "write data on non-ram-write target")

endmodule

bind cartridge_bank_controller_mode_select cbcms_checker u_cbcms_checker (.*);

>>> tb/cartridge_bank_controller_mode_select_test.sv
// self-checking testbench for the single-mode-bit cartridge bank controller
module cartridge_bank_controller_mode_select_test;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no handshake on any channel before the run is abandoned
  localparam int unsigned STALL_LIMIT = 4000;
  // quiet cycles after the last result, well above the length of the divide path
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 170;

  typedef struct packed {
    logic        is_write;
    logic [15:0] addr;
    logic [7:0]  data;
  } bus_access_t;

  typedef struct packed {
    cbcms_pkg::cbcms_target_t    target;
    logic [cbcms_pkg::MAP_W-1:0] mapped;
    logic [7:0]                  wdata;
  } bank_result_t;

  // clock, reset and block ports, the driven inputs known from time zero
  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_req_type = 1'b0;
  logic [15:0]                 in_bus_address = '0;
  logic [7:0]                  in_write_data = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [2:0]                  out_target;
  logic [cbcms_pkg::MAP_W-1:0] out_mapped_address;
  logic [7:0]                  out_ram_write_data;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [1:0]                  cfg_index = '0;
  logic [15:0]                 cfg_data = '0;

  // shadow of the controller state and its two registers, reset values
  logic       ram_en_shadow = 1'b0;
  logic       mode_bit = 1'b0;
  logic [4:0] bank_lo = 5'd1;
  logic [1:0] bank_hi = 2'd0;
  logic [7:0] bank_count = 8'd2;
  logic [15:0] ram_len = 16'd0;

  // stimulus and scoreboard
  bus_access_t  access_queue[$];
  bank_result_t expected_results[$];
  int unsigned  fail_count = 0;
  logic         in_fire = 1'b0;

  // idling control, percent chance per cycle of starting a burst
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned quiet_cycles = 0;

  cartridge_bank_controller_mode_select dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_bus_address    (in_bus_address),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_target        (out_target),
    .out_mapped_address(out_mapped_address),
    .out_ram_write_data(out_ram_write_data),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // combined 7-bit bank folded back into range after a bank register write
  function automatic void fold_bank();
    logic [6:0] full;
    full = {bank_hi, bank_lo};
    if (bank_count != 8'd0) begin
      full = 7'(32'(full) % 32'(bank_count));
    end
    bank_lo = full[4:0];
    bank_hi = full[6:5];
  endfunction

  // cart ram window: mapped only when enabled and the offset is inside the ram
  function automatic bit ram_window_hit(input logic [15:0] addr, output logic [31:0] phys);
    logic [31:0] off;
    phys = '0;
    off = 32'(addr) - 32'hA000;
    if (!ram_en_shadow || off >= 32'(ram_len)) return 1'b0;
    // mode 1 uses the high bank bits as the ram bank
    if (mode_bit) off = off + 32'(bank_hi) * 32'h2000;
    off = off % 32'(ram_len);
    phys = off & ((32'd1 << cbcms_pkg::RAM_ADDR_BITS) - 32'd1);
    return 1'b1;
  endfunction

  // expected result of one bus access, updating the shadow state on writes
  function automatic bank_result_t translate_access(bus_access_t acc);
    bank_result_t res;
    logic [31:0]  phys;
    logic [31:0]  bank;
    res.target = cbcms_pkg::TGT_UNMAPPED;
    res.mapped = '0;
    res.wdata = '0;
    if (!acc.is_write) begin
      case (cbcms_pkg::cbcms_region_t'(acc.addr[15:13]))
        cbcms_pkg::RGN_RAM_EN, cbcms_pkg::RGN_BANK_LO,
        cbcms_pkg::RGN_BANK_HI, cbcms_pkg::RGN_MODE: begin
          res.target = cbcms_pkg::TGT_ROM;
          if (acc.addr[15:14] == 2'b00) begin
            // fixed bank 0 window
            res.mapped = cbcms_pkg::MAP_W'(acc.addr);
          end else begin
            bank = mode_bit ? 32'(bank_lo) : 32'({bank_hi, bank_lo});
            // a bank with zero low bits steps to the next one
            if (bank[4:0] == 5'd0) bank = bank + 32'd1;
            res.mapped = cbcms_pkg::MAP_W'(((32'(acc.addr) - 32'h4000) + bank * 32'h4000)
                                & ((32'd1 << cbcms_pkg::ROM_ADDR_BITS) - 32'd1));
          end
        end
        cbcms_pkg::RGN_CART_RAM: begin
          if (ram_window_hit(acc.addr, phys)) begin
            res.target = cbcms_pkg::TGT_RAM_RD;
            res.mapped = cbcms_pkg::MAP_W'(phys);
          end else begin
            res.target = cbcms_pkg::TGT_OPEN_BUS;
          end
        end
        default: ;
      endcase
    end else begin
      res.target = cbcms_pkg::TGT_REG_WR;
      case (cbcms_pkg::cbcms_region_t'(acc.addr[15:13]))
        cbcms_pkg::RGN_RAM_EN: ram_en_shadow = (acc.data[3:0] == cbcms_pkg::RAM_EN_KEY);
        cbcms_pkg::RGN_BANK_LO: begin
          bank_lo = acc.data[4:0];
          fold_bank();
        end
        cbcms_pkg::RGN_BANK_HI: begin
          bank_hi = acc.data[1:0];
          fold_bank();
        end
        cbcms_pkg::RGN_MODE: mode_bit = acc.data[0];
        cbcms_pkg::RGN_CART_RAM: begin
          if (ram_window_hit(acc.addr, phys)) begin
            res.target = cbcms_pkg::TGT_RAM_WR;
            res.mapped = cbcms_pkg::MAP_W'(phys);
            res.wdata = acc.data;
          end
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  task automatic queue_access(logic is_write, logic [15:0] addr, logic [7:0] data);
    bus_access_t acc;
    acc.is_write = is_write;
    acc.addr = addr;
    acc.data = data;
    access_queue.push_back(acc);
  endtask

  // mostly meaningful accesses with random content, plus some pure noise
  task automatic queue_random_accesses(int unsigned count);
    bus_access_t acc;
    int unsigned pick;
    int unsigned span;
    repeat (count) begin
      pick = $urandom_range(99, 0);
      acc.is_write = 1'($urandom);
      acc.data = 8'($urandom);
      acc.addr = 16'($urandom);
      if (pick < 30) begin
        // rom reads, both windows
        acc.is_write = 1'b0;
        acc.addr = 16'($urandom_range(16'h7FFF, 0));
      end else if (pick < 55) begin
        // control register writes, half of them carrying the enable key
        acc.is_write = 1'b1;
        acc.addr = 16'($urandom_range(16'h7FFF, 0));
        if ($urandom_range(1, 0) != 0) acc.data[3:0] = cbcms_pkg::RAM_EN_KEY;
      end else if (pick < 80) begin
        // cart ram window, biased toward offsets inside the ram
        span = (ram_len != 16'd0 && ram_len < 16'h2000) ? ram_len : 32'h2000;
        if (ram_len != 16'd0 && $urandom_range(1, 0) != 0) begin
          acc.addr = 16'hA000 + 16'($urandom_range(span - 1, 0));
        end else begin
          acc.addr = 16'hA000 + 16'($urandom_range(16'h1FFF, 0));
        end
      end else if (pick < 90) begin
        // video and high regions
        if ($urandom_range(1, 0) != 0) acc.addr = 16'h8000 + 16'($urandom_range(16'h1FFF, 0));
        else acc.addr = 16'hC000 + 16'($urandom_range(16'h3FFF, 0));
      end
      access_queue.push_back(acc);
    end
  endtask

  // register write on the config channel; callers make it only while the block is idle, unchecked by the dut
  task automatic write_register(cbcms_pkg::cbcms_cfg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cbcms_pkg::CFG_ROM_BANK_COUNT: bank_count = value[7:0];
      cbcms_pkg::CFG_RAM_BYTES:      ram_len = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender holds off until every queued item is in and every result is out
  task automatic wait_for_drain();
    do @(posedge clk);
    while (access_queue.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // access driver: new item or idle burst only once the current item is taken
  always @(negedge clk) begin : access_driver
    bus_access_t acc;
    if (rst_n && (!in_valid || in_fire)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (in_idle_pct != 0 && $urandom_range(99, 0) < in_idle_pct) begin
        // idle burst of random length from in_gap, this one included
        in_valid <= 1'b0;
        in_gap <= $urandom_range(15, 0);
      end else if (access_queue.size() != 0) begin
        acc = access_queue.pop_front();
        in_valid <= 1'b1;
        in_req_type <= acc.is_write;
        in_bus_address <= acc.addr;
        in_write_data <= acc.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin : result_sink
    if (out_stall != 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (out_stall_pct != 0 && $urandom_range(99, 0) < out_stall_pct) begin
      out_ready <= 1'b0;
      out_stall <= $urandom_range(15, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: check results in order, then predict the item taken at this edge
  always @(posedge clk) begin : result_monitor
    bank_result_t want;
    bus_access_t  taken;
    if (rst_n) begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no access pending: target %0d mapped_address 0x%06h",
                 out_target, out_mapped_address);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_target !== want.target) begin
            $error("target expected %0d got %0d", want.target, out_target);
            fail_count++;
          end
          if (out_mapped_address !== want.mapped) begin
            $error("mapped_address expected 0x%06h got 0x%06h",
                   want.mapped, out_mapped_address);
            fail_count++;
          end
          if (out_ram_write_data !== want.wdata) begin
            $error("ram_write_data expected 0x%02h got 0x%02h",
                   want.wdata, out_ram_write_data);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        taken.is_write = in_req_type;
        taken.addr = in_bus_address;
        taken.data = in_write_data;
        expected_results.push_back(translate_access(taken));
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    logic [7:0]  count_sel;
    logic [15:0] ram_sel;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: two banks, no ram
    in_idle_pct = 10;
    out_stall_pct = 10;
    queue_access(1'b0, 16'h0000, 8'h00);
    queue_access(1'b0, 16'h3FFF, 8'hFF);
    queue_access(1'b0, 16'h4000, 8'h00);
    queue_access(1'b0, 16'h8000, 8'h00);
    queue_access(1'b1, 16'h0000, 8'h0A);
    // ram enabled but zero size reads open bus
    queue_access(1'b0, 16'hA000, 8'h00);
    queue_access(1'b1, 16'hBFFF, 8'hFF);
    // bank 0 selection steps to bank 1
    queue_access(1'b1, 16'h2000, 8'h00);
    queue_access(1'b0, 16'h7FFF, 8'h00);
    // writes outside the mapper absorb without effect
    queue_access(1'b1, 16'hFFFF, 8'hFF);
    queue_access(1'b0, 16'hFFFF, 8'h00);
    queue_access(1'b1, 16'h8000, 8'h5A);
    wait_for_drain();

    // directed, largest rom and ram
    write_register(cbcms_pkg::CFG_ROM_BANK_COUNT, 16'd128);
    write_register(cbcms_pkg::CFG_RAM_BYTES, 16'd32768);
    queue_access(1'b1, 16'h1FFF, 8'hFA);
    queue_access(1'b1, 16'h3FFF, 8'hFF);
    queue_access(1'b1, 16'h5FFF, 8'hFF);
    // bank 127 at the top of the rom address space
    queue_access(1'b0, 16'h7FFF, 8'h00);
    // low bits zero with high bits set steps to the next bank
    queue_access(1'b1, 16'h2000, 8'hE0);
    queue_access(1'b0, 16'h4000, 8'h00);
    queue_access(1'b1, 16'h6000, 8'h01);
    queue_access(1'b0, 16'h4000, 8'h00);
    // mode 1 ram banking through the high bits
    queue_access(1'b0, 16'hBFFF, 8'h00);
    queue_access(1'b1, 16'hA000, 8'hFF);
    queue_access(1'b1, 16'h7FFF, 8'hFE);
    queue_access(1'b1, 16'h0000, 8'h0B);
    queue_access(1'b0, 16'hA123, 8'h00);
    wait_for_drain();

    // random phases over several settings, ending with no idling at all
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      ram_sel = 16'($urandom_range(32768, 1));
      case ($urandom_range(5, 0))
        0: ram_sel = 16'd0;
        1: ram_sel = 16'd512;
        2: ram_sel = 16'd2048;
        3: ram_sel = 16'd8192;
        4: ram_sel = 16'd32768;
        default: ;
      endcase
      count_sel = 8'($urandom_range(128, 2));
      case (phase)
        0: begin
          // zero bank count leaves the bank unreduced
          count_sel = 8'd0;
          ram_sel = 16'd8192;
        end
        1: begin
          // one-byte ram, only offset zero is mapped
          count_sel = 8'd2;
          ram_sel = 16'd1;
        end
        2: begin
          count_sel = 8'd128;
          ram_sel = 16'd32768;
        end
        3: begin
          count_sel = 8'd3;
          ram_sel = 16'd2048;
        end
        RANDOM_PHASES - 1: ram_sel = 16'd32768;
        default: ;
      endcase
      // some phases run without gaps, the last one included
      if (phase == RANDOM_PHASES - 1 || phase % 3 == 1) begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end else begin
        in_idle_pct = $urandom_range(25, 5);
        out_stall_pct = $urandom_range(25, 5);
      end
      write_register(cbcms_pkg::CFG_ROM_BANK_COUNT, 16'(count_sel));
      write_register(cbcms_pkg::CFG_RAM_BYTES, ram_sel);
      queue_random_accesses(ITEMS_PER_PHASE);
      wait_for_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> cartridge_bank_controller_mode_select.f
+incdir+hdl
hdl/cbcms_pkg.sv
hdl/cbcms_rem.sv
hdl/cbcms_ctrl.sv
hdl/cbcms_dp.sv
hdl/cartridge_bank_controller_mode_select.sv
hdl/cbcms_checker.sv
tb/cartridge_bank_controller_mode_select_test.sv
